// ===== rtl/lbp8u_pkg.sv =====
// Shared constants, types and the uniform-pattern bin table for the LBP8 pixel stream block.
package lbp8u_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MIN_DIM      = 3;

  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int PIX_W        = 8;

  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_UNIFORM_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pattern;
    logic [11:0]      center_row;
    logic [10:0]      center_col;
    logic             frame_last;
  } res_t;

  // One pixel on its way from the acceptance cycle to the window stage.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             fwd;
    logic [11:0]      center_row;
    logic [10:0]      center_col;
    logic             frame_last;
  } s1_item_t;

  typedef logic [PIX_W-1:0] bin_table_t [256];

  // Codes with at most two circular transitions are numbered from 1 in code order.
  function automatic bin_table_t build_bin_table();
    bin_table_t  tbl;
    logic [7:0]  code;
    logic [7:0]  rot;
    logic [7:0]  diff;
    int          next_bin;
    next_bin = 1;
    for (int i = 0; i < 256; i++) begin
      code = 8'(i);
      rot  = {code[6:0], code[7]};
      diff = code ^ rot;
      if ($countones(diff) <= 2) begin
        tbl[i]   = 8'(next_bin);
        next_bin = next_bin + 1;
      end else begin
        tbl[i] = '0;
      end
    end
    return tbl;
  endfunction

  localparam bin_table_t BIN_TABLE = build_bin_table();

endpackage

// ===== rtl/lbp8u_stream_if.sv =====
// Valid/ready channel interfaces for incoming pixels and outgoing patterns.
interface lbp8u_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp8u_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pattern;
  logic [11:0] center_row;
  logic [10:0] center_col;
  logic        frame_last;

  modport source (output valid, output pattern, output center_row, output center_col,
                  output frame_last, input ready);
  modport sink   (input valid, input pattern, input center_row, input center_col,
                  input frame_last, output ready);
endinterface

// ===== rtl/lbp8u_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lbp8u_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lbp8u_window.sv =====
// Window stage: line buffer write-back with forwarding, 3x3 window and pattern compare.
module lbp8u_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s1_valid,
  input  lbp8u_pkg::s1_item_t        s1,
  input  logic                       uniform_mode,
  input  logic [lbp8u_pkg::PIX_W-1:0] rd_two,
  input  logic [lbp8u_pkg::PIX_W-1:0] rd_one,
  output logic [lbp8u_pkg::PIX_W-1:0] wr_two,
  output logic [lbp8u_pkg::PIX_W-1:0] wr_one,
  output logic                       push,
  output lbp8u_pkg::res_t            push_data
);
  import lbp8u_pkg::*;

  logic [PIX_W-1:0] top1, top2, mid1, mid2, bot1, bot2;
  logic [PIX_W-1:0] last_two, last_one;
  logic [PIX_W-1:0] two_eff, one_eff, ctr;
  logic [7:0]       code;

  // A read issued in the same cycle as the previous write to that entry sees stale data.
  assign two_eff = s1.fwd ? last_two : rd_two;
  assign one_eff = s1.fwd ? last_one : rd_one;
  assign wr_two  = one_eff;
  assign wr_one  = s1.pixel;

  assign ctr = mid2;
  always_comb begin
    code[7] = top1     > ctr;
    code[6] = top2     > ctr;
    code[5] = two_eff  > ctr;
    code[4] = one_eff  > ctr;
    code[3] = s1.pixel > ctr;
    code[2] = bot2     > ctr;
    code[1] = bot1     > ctr;
    code[0] = mid1     > ctr;
  end

  assign push                 = s1_valid && s1.emit;
  assign push_data.pattern    = uniform_mode ? BIN_TABLE[code] : code;
  assign push_data.center_row = s1.center_row;
  assign push_data.center_col = s1.center_col;
  assign push_data.frame_last = s1.frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      top1 <= '0;
      top2 <= '0;
      mid1 <= '0;
      mid2 <= '0;
      bot1 <= '0;
      bot2 <= '0;
    end else if (s1_valid) begin
      top1 <= top2;
      top2 <= two_eff;
      mid1 <= mid2;
      mid2 <= one_eff;
      bot1 <= bot2;
      bot2 <= s1.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      last_two <= one_eff;
      last_one <= s1.pixel;
    end
  end

endmodule

// ===== rtl/lbp8u_out_queue.sv =====
// Three-entry result queue that decouples the window stage from the output handshake.
module lbp8u_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lbp8u_pkg::res_t     push_data,
  output logic [1:0]          level,
  lbp8u_res_if.source         results
);
  import lbp8u_pkg::*;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  res_t       slots [3];
  logic [1:0] wr_ptr, rd_ptr, count;
  logic       pop;
  res_t       head;

  assign head               = slots[rd_ptr];
  assign results.valid      = count != 2'd0;
  assign results.pattern    = head.pattern;
  assign results.center_row = head.center_row;
  assign results.center_col = head.center_col;
  assign results.frame_last = head.frame_last;
  assign pop                = results.valid && results.ready;
  assign level              = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? 2'd0 : rd_ptr + 2'd1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/lbp8_uniform_pixel_stream.sv =====
// Top level of the LBP8 pixel stream block: counters, line buffers, window stage and output queue.
//
// This block takes grey pixels in raster order, one transaction per clock while ready, and
// for every interior pixel of the frame produces one transaction carrying the
// 8-bit local binary pattern of its 3x3 neighborhood (bit 7 is the top-left
// neighbor, continuing clockwise, set when that neighbor is strictly brighter
// than the center), or, with uniform_mode set, its uniform-pattern bin 0..58.
// Border pixels produce nothing, so the first result of a frame follows the
// third pixel of row 2. The block sustains one pixel per clock while its output
// queue has room: the two line buffers are synchronous RAMs read and written
// once per pixel, and a pixel is registered as the window stage item, whose
// pattern is written into the output queue before it is offered. A three-entry
// queue on the output lets the pixel side keep streaming through short stalls
// of the result side. There is no clearing pass after reset; a line buffer entry
// is only used in a result after it has been written in the current frame geometry.
// Configuration registers must be written while the block is idle. Width and
// height are clamped to 3..2048 and 3..4096. Frame_start restarts the
// position counters on the pixel that carries it; otherwise the counters wrap
// to the start of a new frame after the last pixel of a frame. No pixel is
// taken while reset is high.
module lbp8_uniform_pixel_stream (
  input  logic                              clk,
  input  logic                              rst,
  lbp8u_pix_if.sink                         pixels,
  lbp8u_res_if.source                       results,
  input  logic                              wr_en,
  input  logic [lbp8u_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [lbp8u_pkg::CFG_DATA_W-1:0]  wr_data
);
  import lbp8u_pkg::*;

  // Configuration registers.
  logic                    uniform_mode;
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_mode <= 1'b0;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_UNIFORM_MODE: uniform_mode <= wr_data[0];
        REG_IMAGE_WIDTH:  image_width  <= wr_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= wr_data[HEIGHT_REG_W-1:0];
        default:          uniform_mode <= uniform_mode;
      endcase
    end
  end

  // Effective geometry, clamped to what the line buffers and counters hold.
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  always_comb begin
    priority if (image_width < WIDTH_REG_W'(MIN_DIM)) begin
      w_eff = WIDTH_REG_W'(MIN_DIM);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    priority if (image_height < HEIGHT_REG_W'(MIN_DIM)) begin
      h_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // Position counters. The column count is also the line buffer address.
  logic [COL_W-1:0] column_count, col_cur;
  logic [ROW_W-1:0] row_count, row_cur;
  logic             in_fire, col_wrap, row_wrap;
  logic             s1_valid;
  s1_item_t         s1, s1_next;
  logic [1:0]       level;

  // The queue must have room for the item in the window stage and this one.
  assign pixels.ready = !rst && (({1'b0, level} + {2'b00, s1_valid}) <= 3'd2);
  assign in_fire      = pixels.valid && pixels.ready;

  assign col_cur  = pixels.frame_start ? '0 : column_count;
  assign row_cur  = pixels.frame_start ? '0 : row_count;
  assign col_wrap = (WIDTH_REG_W'(col_cur) + WIDTH_REG_W'(1)) >= w_eff;
  assign row_wrap = (HEIGHT_REG_W'(row_cur) + HEIGHT_REG_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_cur + ROW_W'(1);
      end else begin
        column_count <= col_cur + COL_W'(1);
        row_count    <= row_cur;
      end
    end
  end

  // Item for the window stage; the line buffer read at col_cur lands next cycle.
  always_comb begin
    s1_next.pixel      = pixels.pixel;
    s1_next.addr       = col_cur;
    s1_next.emit       = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    s1_next.fwd        = s1_valid && (s1.addr == col_cur);
    s1_next.center_row = 12'(row_cur - ROW_W'(1));
    s1_next.center_col = 11'(col_cur - COL_W'(1));
    s1_next.frame_last = row_wrap && col_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  // Line buffers: the row two above and the row one above the incoming pixel.
  logic [PIX_W-1:0] rd_two, rd_one, wr_two, wr_one;
  logic             push;
  res_t             push_data;

  lbp8u_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.addr),
    .wdata (wr_two),
    .raddr (col_cur),
    .rdata (rd_two)
  );

  lbp8u_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one_above (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.addr),
    .wdata (wr_one),
    .raddr (col_cur),
    .rdata (rd_one)
  );

  lbp8u_window u_window (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .uniform_mode (uniform_mode),
    .rd_two       (rd_two),
    .rd_one       (rd_one),
    .wr_two       (wr_two),
    .wr_one       (wr_one),
    .push         (push),
    .push_data    (push_data)
  );

  lbp8u_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .level     (level),
    .results   (results)
  );

endmodule

// ===== verif/lbp8_uniform_pixel_stream_tb.sv =====
// Self-checking testbench for the LBP8 pixel stream block with its own pattern predictor.
module lbp8_uniform_pixel_stream_tb;
  import lbp8u_pkg::*;

  // Pixels in the directed part and the rough size of the random part that follows it.
  localparam int unsigned DIRECTED_PIXELS = 18;
  localparam int unsigned STREAM_PIXELS   = 1200;
  // Quiet cycles allowed after the last expected pattern before a register write.
  // Border pixels produce nothing, so the pipeline may still be busy at that point.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 16;
  // Length of the long receiver stall that backs the block up into its pixel port.
  localparam int unsigned LONG_HOLD       = 64;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS     = 10;

  // What one entry of the stimulus queue asks the pixel driver to do.
  typedef enum logic [1:0] {
    ITEM_PIXEL,   // offer one pixel transaction
    ITEM_DRAIN,   // hold off until every expected pattern has arrived
    ITEM_WRITE    // write one configuration register
  } item_kind_e;

  // How the pixels of one generated frame are drawn.
  typedef enum logic [1:0] {
    TEX_NOISE,     // uniform over 0..255
    TEX_TIES,      // base value plus 0..2 (minus near 255), so neighbors often equal the center
    TEX_BINARY,    // only 0 and 255
    TEX_CONSTANT   // flat frame, every raw code is zero
  } texture_e;

  typedef struct {
    item_kind_e                kind;
    logic [7:0]                pixel;
    logic                      frame_start;
    logic [CFG_INDEX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]     data;
    int unsigned               gap;
  } stim_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  lbp8u_pix_if pix_ch ();
  lbp8u_res_if pat_ch ();

  lbp8_uniform_pixel_stream DUT (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pix_ch),
    .results  (pat_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block: two line buffers, the 3x3 window,
  // the raster position and the three registers. The line buffers are only
  // used for a pattern where the stimulus has written them in the current geometry.
  // ---------------------------------------------------------------------------
  logic [7:0]        row_above2 [MAX_WIDTH];
  logic [7:0]        row_above1 [MAX_WIDTH];
  logic [7:0]        win3x3 [9];     // index row*3 + col, col 2 is the newest
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;
  logic              uniform_sel = 1'b0;
  logic [11:0]       width_reg = WIDTH_RESET;
  logic [12:0]       height_reg = HEIGHT_RESET;
  logic [7:0]        uniform_bin [256];

  // Patterns still owed by the block, oldest first.
  res_t              pattern_q [$];

  stim_item_t        stim_q [$];

  // Bookkeeping shown in the summary and used for the verdict.
  int unsigned       failures = 0;
  int unsigned       pixels_accepted = 0;
  int unsigned       patterns_checked = 0;
  int unsigned       writes_done = 0;

  // Generator view of the geometry, used to size frames and to decide when a
  // widened frame has to restart so that no stale line buffer entry is used.
  int unsigned       gen_w = WIDTH_RESET;
  int unsigned       gen_h = HEIGHT_RESET;
  logic              force_start = 1'b1;
  logic              tx_burst = 1'b0;
  int unsigned       pixels_queued = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Number of 0/1 changes around the circular 8-bit code.
  function automatic int unsigned ring_transitions(logic [7:0] code);
    int unsigned n = 0;
    for (int b = 0; b < 8; b++) begin
      if (code[b] != code[(b + 1) % 8]) n++;
    end
    return n;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("MISMATCH %0d: %s", failures, msg);
  endtask

  task automatic apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_UNIFORM_MODE: uniform_sel = data[0];
      REG_IMAGE_WIDTH:  width_reg = data[11:0];
      REG_IMAGE_HEIGHT: height_reg = data[12:0];
      default: ;
    endcase
  endtask

  // Advances the window by one accepted pixel and queues the pattern it
  // completes, if its center is an interior pixel.
  task automatic predict_pixel(logic [7:0] px, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [7:0]  ctr;
    logic [7:0]  code;
    res_t        want;
    w = clamp_dim(int'(width_reg), MAX_WIDTH);
    h = clamp_dim(int'(height_reg), MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int k = 0; k < 3; k++) begin
      win3x3[k*3]     = win3x3[k*3 + 1];
      win3x3[k*3 + 1] = win3x3[k*3 + 2];
    end
    win3x3[2] = row_above2[c];
    win3x3[5] = row_above1[c];
    row_above2[c] = row_above1[c];
    row_above1[c] = px;
    win3x3[8] = px;

    if (r >= 2 && c >= 2) begin
      ctr  = win3x3[4];
      // Clockwise from the top-left neighbor; a bit is set only when the
      // neighbor is strictly brighter than the center.
      code = {win3x3[0] > ctr, win3x3[1] > ctr, win3x3[2] > ctr, win3x3[5] > ctr,
              win3x3[8] > ctr, win3x3[7] > ctr, win3x3[6] > ctr, win3x3[3] > ctr};
      if (uniform_sel) code = uniform_bin[code];
      want.pattern    = code;
      want.center_row = 12'(r - 1);
      want.center_col = 11'(c - 1);
      want.frame_last = (r + 1 >= h) && (c + 1 >= w);
      pattern_q.push_back(want);
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_pattern(res_t got);
    res_t want;
    if (pattern_q.size() == 0) begin
      note_failure($sformatf("unexpected pattern %0d at row %0d col %0d last %0b",
                             got.pattern, got.center_row, got.center_col, got.frame_last));
      return;
    end
    want = pattern_q.pop_front();
    if (got.pattern !== want.pattern || got.center_row !== want.center_row ||
        got.center_col !== want.center_col || got.frame_last !== want.frame_last) begin
      note_failure($sformatf(
        "expected pattern %0d row %0d col %0d last %0b, got %0d row %0d col %0d last %0b",
        want.pattern, want.center_row, want.center_col, want.frame_last,
        got.pattern, got.center_row, got.center_col, got.frame_last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus queue builders. Every pixel draws its own lead-in gap unless the
  // current stretch is a burst.
  // ---------------------------------------------------------------------------
  task automatic add_pixel(logic [7:0] px, logic fs);
    stim_item_t it;
    it.kind        = ITEM_PIXEL;
    it.pixel       = px;
    it.frame_start = fs | force_start;
    it.index       = REG_UNIFORM_MODE;
    it.data        = '0;
    it.gap         = tx_burst ? 0 : $urandom_range(0, 3);
    force_start    = 1'b0;
    pixels_queued++;
    stim_q.push_back(it);
  endtask

  task automatic add_drain();
    stim_item_t it;
    it.kind        = ITEM_DRAIN;
    it.pixel       = '0;
    it.frame_start = 1'b0;
    it.index       = REG_UNIFORM_MODE;
    it.data        = '0;
    it.gap         = 0;
    stim_q.push_back(it);
  endtask

  // A wider geometry means columns past the old width hold nothing from the
  // rows above, so the next pixel is forced to start a fresh frame.
  task automatic add_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_item_t  it;
    int unsigned eff;
    it.kind        = ITEM_WRITE;
    it.pixel       = '0;
    it.frame_start = 1'b0;
    it.index       = idx;
    it.data        = data;
    it.gap         = 0;
    stim_q.push_back(it);
    if (idx == REG_IMAGE_WIDTH) begin
      eff = clamp_dim(int'(data[11:0]), MAX_WIDTH);
      if (eff > gen_w) force_start = 1'b1;
      gen_w = eff;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      gen_h = clamp_dim(int'(data), MAX_HEIGHT);
    end
  endtask

  // Queues count pixels of one texture; a noisy run scatters stray frame starts.
  task automatic add_frame(int unsigned count, logic first_start, logic noisy);
    texture_e   tex;
    logic [7:0] base;
    logic [7:0] px;
    tex  = texture_e'($urandom_range(0, 3));
    base = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < count; i++) begin
      case (tex)
        TEX_NOISE:  px = 8'($urandom_range(0, 255));
        TEX_TIES:   px = (base > 8'd253) ? base - 8'($urandom_range(0, 2))
                                         : base + 8'($urandom_range(0, 2));
        TEX_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:    px = base;
      endcase
      add_pixel(px, (i == 0 && first_start) || (noisy && $urandom_range(0, 63) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver. It works through the stimulus queue: pixels are offered
  // after their gap, a drain waits for the pattern queue to empty and then a
  // few quiet cycles, and a write pulses the configuration port for one cycle.
  // Next-cycle values are worked out first so that each signal receives a
  // single nonblocking assignment per clock edge.
  // ---------------------------------------------------------------------------
  logic                   drv_valid = 1'b0;
  logic [7:0]             drv_pixel = '0;
  logic                   drv_start = 1'b0;
  logic                   drv_wr;
  logic [CFG_INDEX_W-1:0] drv_index = REG_UNIFORM_MODE;
  logic [CFG_DATA_W-1:0]  drv_data = '0;
  int unsigned            quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      drv_valid          = 1'b0;
      pix_ch.valid       <= 1'b0;
      pix_ch.pixel       <= '0;
      pix_ch.frame_start <= 1'b0;
      wr_en              <= 1'b0;
      wr_index           <= REG_UNIFORM_MODE;
      wr_data            <= '0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        predict_pixel(pix_ch.pixel, pix_ch.frame_start);
        pixels_accepted++;
      end
      drv_valid = pix_ch.valid && !pix_ch.ready;
      drv_wr    = 1'b0;
      if (!drv_valid && stim_q.size() != 0) begin
        case (stim_q[0].kind)
          ITEM_PIXEL: begin
            if (stim_q[0].gap > 0) begin
              stim_q[0].gap = stim_q[0].gap - 1;
            end else begin
              drv_valid = 1'b1;
              drv_pixel = stim_q[0].pixel;
              drv_start = stim_q[0].frame_start;
              void'(stim_q.pop_front());
            end
          end
          ITEM_DRAIN: begin
            if (pattern_q.size() != 0) begin
              quiet_cycles = 0;
            end else if (quiet_cycles < SETTLE_CYCLES) begin
              quiet_cycles++;
            end else begin
              quiet_cycles = 0;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            // The block samples the write at the next edge, before any new
            // pixel can reach it, so the predictor takes it right away.
            drv_wr    = 1'b1;
            drv_index = stim_q[0].index;
            drv_data  = stim_q[0].data;
            apply_write(drv_index, drv_data);
            writes_done++;
            void'(stim_q.pop_front());
          end
        endcase
      end
      pix_ch.valid       <= drv_valid;
      pix_ch.pixel       <= drv_pixel;
      pix_ch.frame_start <= drv_start;
      wr_en              <= drv_wr;
      wr_index           <= drv_index;
      wr_data            <= drv_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Pattern monitor. Ready may drop after each transaction, runs without gaps
  // in alternate stretches of 256 patterns, and now and then holds off for a
  // long stretch so that the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        rx_ready;
  res_t        seen;

  always @(posedge clk) begin
    if (rst) begin
      rx_gap        = 0;
      hold_left     = 0;
      pat_ch.ready <= 1'b0;
    end else begin
      if (pat_ch.valid && pat_ch.ready) begin
        seen.pattern    = pat_ch.pattern;
        seen.center_row = pat_ch.center_row;
        seen.center_col = pat_ch.center_col;
        seen.frame_last = pat_ch.frame_last;
        check_pattern(seen);
        patterns_checked++;
        rx_gap = ((patterns_checked >> 8) & 1) ? 0 : $urandom_range(0, 3);
        if (patterns_checked % 200 == 100) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rx_ready = 1'b0;
      end else begin
        rx_ready = 1'b1;
      end
      pat_ch.ready <= rx_ready;
    end
  end

  // Watchdog: a run that stops making progress ends as a failure.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (pat_ch.valid && pat_ch.ready) || wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d patterns still owed",
               idle_cycles, pattern_q.size());
      $display("lbp8_uniform_pixel_stream_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  frame_a [9];
    logic [7:0]  frame_b [9];
    int unsigned next_bin;
    int unsigned frame_px;
    int unsigned split;

    // Frame A: center 128 with a brighter, an equal and darker neighbors.
    frame_a = '{8'd255, 8'd128, 8'd0,
                8'd129, 8'd128, 8'd127,
                8'd128, 8'd200, 8'd10};
    // Frame B: dark center, one neighbor equal to it, the rest at full scale.
    frame_b = '{8'd255, 8'd255, 8'd255,
                8'd255, 8'd0,   8'd255,
                8'd255, 8'd255, 8'd0};

    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    pat_ch.ready       = 1'b0;
    wr_en              = 1'b0;
    wr_index           = REG_UNIFORM_MODE;
    wr_data            = '0;

    next_bin = 1;
    for (int i = 0; i < 256; i++) begin
      if (ring_transitions(8'(i)) <= 2) begin
        uniform_bin[i] = 8'(next_bin);
        next_bin++;
      end else begin
        uniform_bin[i] = '0;
      end
    end
    foreach (win3x3[i]) win3x3[i] = '0;

    // Directed part: the smallest frame twice in raw mode. The second frame
    // carries no frame start and relies on the counters wrapping at the end
    // of the first one.
    tx_burst = 1'b1;
    add_write(REG_UNIFORM_MODE, '0);
    add_write(REG_IMAGE_WIDTH, 13'd3);
    add_write(REG_IMAGE_HEIGHT, 13'd3);
    foreach (frame_a[i]) add_pixel(frame_a[i], i == 0);
    foreach (frame_b[i]) add_pixel(frame_b[i], 1'b0);

    // Random part: each phase drains, reprograms all three registers (widths
    // and heights below the minimum included) and streams one or two frames.
    // Most frames are complete; some are cut short and restarted, some carry
    // stray frame starts, and some change a register mid-frame.
    while (pixels_queued < DIRECTED_PIXELS + STREAM_PIXELS) begin
      add_drain();
      tx_burst = ($urandom_range(0, 3) == 0);
      add_write(REG_UNIFORM_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
        0:       add_write(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
        1:       add_write(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(13, 40)));
        default: add_write(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(3, 12)));
      endcase
      if ($urandom_range(0, 5) == 0) begin
        add_write(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
      end else begin
        add_write(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 6)));
      end
      repeat ($urandom_range(1, 2)) begin
        frame_px = gen_w * gen_h;
        case ($urandom_range(0, 5))
          0: begin
            add_frame($urandom_range(1, frame_px - 1), 1'($urandom_range(0, 1)), 1'b1);
            force_start = 1'b1;
          end
          1: begin
            // A narrower width, a new height or a mode flip while the
            // counters sit inside a frame; a wider width would expose
            // columns the rows above never filled.
            split = $urandom_range(1, frame_px - 1);
            add_frame(split, 1'b1, 1'b0);
            add_drain();
            case ($urandom_range(0, 2))
              0:       add_write(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, gen_w)));
              1:       add_write(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 9)));
              default: add_write(REG_UNIFORM_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            endcase
            add_frame($urandom_range(1, gen_w * gen_h), 1'b0, 1'b0);
          end
          default: add_frame(frame_px, $urandom_range(0, 3) != 0, 1'b0);
        endcase
      end
    end

    // Out-of-range width and height values that saturate, each followed by a
    // short stretch of a frame: no wrap at the old small geometry may occur.
    add_drain();
    tx_burst = 1'b0;
    add_write(REG_UNIFORM_MODE, 13'd1);
    add_write(REG_IMAGE_WIDTH, 13'h0FFF);
    add_write(REG_IMAGE_HEIGHT, 13'd3);
    add_frame(64, 1'b1, 1'b0);
    add_drain();
    add_write(REG_UNIFORM_MODE, '0);
    add_write(REG_IMAGE_WIDTH, 13'd3);
    add_write(REG_IMAGE_HEIGHT, 13'h1FFF);
    add_frame(60, 1'b1, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || drv_valid || pattern_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d pixels, %0d patterns checked, %0d register writes",
             pixels_accepted, patterns_checked, writes_done);
    $display("raw and uniform codes, clamped and saturated geometry, restarts and wraps");
    if (failures == 0) begin
      $display("lbp8_uniform_pixel_stream_tb: clean");
    end else begin
      $display("lbp8_uniform_pixel_stream_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lbp8u_pkg.sv
rtl/lbp8u_stream_if.sv
rtl/lbp8u_ram.sv
rtl/lbp8u_window.sv
rtl/lbp8u_out_queue.sv
rtl/lbp8_uniform_pixel_stream.sv
verif/lbp8_uniform_pixel_stream_tb.sv
